// ===== hdl/wrct_pkg.sv =====
// shared types and constants for the withdrawn route count table
// request and response words, command and status codes, sequencer states
// no dependencies
package wrct_pkg;

   localparam int PREFIX_FIELD_BITS = 40;
   localparam int COUNT_BITS        = 32;
   localparam int REMOVED_BITS      = 7;
   localparam logic [REMOVED_BITS-1:0] REMOVED_MAX = '1;

   localparam logic CMD_RECORD = 1'b0;
   localparam logic CMD_FLUSH  = 1'b1;

   localparam logic [1:0] STATUS_UPDATED  = 2'd0;
   localparam logic [1:0] STATUS_INSERTED = 2'd1;
   localparam logic [1:0] STATUS_FULL     = 2'd2;
   localparam logic [1:0] STATUS_FLUSHED  = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_SCAN,
      ST_LAST,
      ST_COMMIT
   } state_type;

   typedef struct packed {
      logic                         cmd;
      logic [31:0]                  peer_id;
      logic [PREFIX_FIELD_BITS-1:0] prefix_key;
      logic [31:0]                  withdraw_time;
      logic [COUNT_BITS-1:0]        prior_count;
   } req_word_type;

   typedef struct packed {
      logic [1:0]              status;
      logic [COUNT_BITS-1:0]   entry_count;
      logic [REMOVED_BITS-1:0] removed;
   } rsp_word_type;

   function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
      logic [COUNT_BITS-1:0] r;
      r = (v == '1) ? v : v + COUNT_BITS'(1);
      return r;
   endfunction

endpackage

// ===== hdl/wrct_ram.sv =====
// generic simple dual port ram: one write port, one read port, registered read
// no dependencies
module wrct_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/withdrawn_route_count_table_core.sv =====
// top level of the withdrawn route count table: sequencer and scan datapath
// depends on wrct_pkg and wrct_ram
//
// usage
//   request channel: drive req_word and raise start; the word is taken at a
//   rising edge where start is high and busy is low. cmd record looks up
//   (peer_id, prefix_key); a hit bumps the stored count (saturating) and the
//   time, a miss fills the lowest free slot with prior_count plus one, and a
//   full table drops the word. cmd flush invalidates every slot of peer_id.
//   response channel: one rsp_word per request, valid for exactly one cycle
//   while rsp_strobe is high. the receiver cannot stall; it must sample it.
//   sweep: the table lives in one ram and is swept one slot per cycle; a
//   request passes through the scan, last and commit states, and its
//   response is registered out of commit. busy falls as the response is
//   shown, so a new request is taken only once the last one has answered.
//   reset: synchronous, active high. afterwards a clearing pass over every
//   slot zeroes the valid flags in the ram; busy stays high until it ends.
//   only the low min(PREFIX_KEY_BITS, 40) bits of prefix_key are kept
module withdrawn_route_count_table_core #(
   parameter int TABLE_ENTRIES   = 64,
   parameter int PREFIX_KEY_BITS = 40
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  wrct_pkg::req_word_type req_word,
   output logic                  rsp_strobe,
   output wrct_pkg::rsp_word_type rsp_word
);

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int KEY_W = (PREFIX_KEY_BITS < wrct_pkg::PREFIX_FIELD_BITS) ?
                          PREFIX_KEY_BITS : wrct_pkg::PREFIX_FIELD_BITS;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

   // one ram word per slot
   typedef struct packed {
      logic                            valid;
      logic [31:0]                     peer;
      logic [KEY_W-1:0]                prefix;
      logic [wrct_pkg::COUNT_BITS-1:0] count;
      logic [31:0]                     stamp;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // sequencer and scan registers
   wrct_pkg::state_type state_ff, state_in;
   wrct_pkg::req_word_type req_ff, req_in;
   logic [IDX_W-1:0] rd_addr_ff, rd_addr_in;
   logic             chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0] chk_addr_ff, chk_addr_in;
   logic             hit_ff, hit_in;
   logic [IDX_W-1:0] hit_addr_ff, hit_addr_in;
   logic [wrct_pkg::COUNT_BITS-1:0] hit_count_ff, hit_count_in;
   logic             free_ff, free_in;
   logic [IDX_W-1:0] free_addr_ff, free_addr_in;
   logic [wrct_pkg::REMOVED_BITS-1:0] removed_ff, removed_in;
   logic             rsp_valid_ff, rsp_valid_in;
   wrct_pkg::rsp_word_type rsp_word_ff, rsp_word_in;

   // ram port signals
   logic             ram_wr_en;
   logic [IDX_W-1:0] ram_wr_addr;
   entry_type        ram_wr_data;
   logic             ram_rd_en;
   entry_type        ram_rd_data;
   logic [ENTRY_W-1:0] ram_rd_bits;

   logic             accept;
   logic             peer_match;
   logic             key_match;
   logic [wrct_pkg::COUNT_BITS-1:0] new_count;

   assign accept      = start && (state_ff == wrct_pkg::ST_IDLE);
   assign ram_rd_data = entry_type'(ram_rd_bits);
   assign peer_match  = ram_rd_data.peer == req_ff.peer_id;
   assign key_match   = ram_rd_data.prefix == req_ff.prefix_key[KEY_W-1:0];
   // hit bumps the stored count, insert starts from the carried count
   assign new_count   = hit_ff ? wrct_pkg::sat_inc(hit_count_ff)
                               : wrct_pkg::sat_inc(req_ff.prior_count);

   wrct_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(TABLE_ENTRIES)
   ) u_table (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(rd_addr_ff),
      .rd_data(ram_rd_bits)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         wrct_pkg::ST_IDLE: begin
            if (start) begin
               state_in = wrct_pkg::ST_SCAN;
            end
         end
         wrct_pkg::ST_CLEAR: begin
            if (rd_addr_ff == LAST_IDX) begin
               state_in = wrct_pkg::ST_IDLE;
            end
         end
         wrct_pkg::ST_SCAN: begin
            if (rd_addr_ff == LAST_IDX) begin
               state_in = wrct_pkg::ST_LAST;
            end
         end
         wrct_pkg::ST_LAST:   state_in = wrct_pkg::ST_COMMIT;
         wrct_pkg::ST_COMMIT: state_in = wrct_pkg::ST_IDLE;
         default:             state_in = wrct_pkg::ST_IDLE;
      endcase
   end

   // datapath and ram control
   always_comb begin
      req_in       = req_ff;
      rd_addr_in   = rd_addr_ff;
      chk_vld_in   = (state_ff == wrct_pkg::ST_SCAN);
      chk_addr_in  = rd_addr_ff;
      hit_in       = hit_ff;
      hit_addr_in  = hit_addr_ff;
      hit_count_in = hit_count_ff;
      free_in      = free_ff;
      free_addr_in = free_addr_ff;
      removed_in   = removed_ff;
      rsp_valid_in = 1'b0;
      rsp_word_in  = rsp_word_ff;
      ram_rd_en    = (state_ff == wrct_pkg::ST_SCAN);
      ram_wr_en    = 1'b0;
      ram_wr_addr  = chk_addr_ff;
      ram_wr_data  = ram_rd_data;

      case (state_ff)
         wrct_pkg::ST_CLEAR: begin
            // sweep the valid flags out after reset
            ram_wr_en   = 1'b1;
            ram_wr_addr = rd_addr_ff;
            ram_wr_data = '0;
            rd_addr_in  = rd_addr_ff + IDX_W'(1);
         end
         wrct_pkg::ST_SCAN: begin
            rd_addr_in = rd_addr_ff + IDX_W'(1);
         end
         wrct_pkg::ST_COMMIT: begin
            rsp_valid_in         = 1'b1;
            rsp_word_in.removed  = '0;
            rsp_word_in.entry_count = '0;
            if (req_ff.cmd == wrct_pkg::CMD_FLUSH) begin
               rsp_word_in.status  = wrct_pkg::STATUS_FLUSHED;
               rsp_word_in.removed = removed_ff;
            end else if (hit_ff || free_ff) begin
               rsp_word_in.status      = hit_ff ? wrct_pkg::STATUS_UPDATED
                                                : wrct_pkg::STATUS_INSERTED;
               rsp_word_in.entry_count = new_count;
               ram_wr_en          = 1'b1;
               ram_wr_addr        = hit_ff ? hit_addr_ff : free_addr_ff;
               ram_wr_data.valid  = 1'b1;
               ram_wr_data.peer   = req_ff.peer_id;
               ram_wr_data.prefix = req_ff.prefix_key[KEY_W-1:0];
               ram_wr_data.count  = new_count;
               ram_wr_data.stamp  = req_ff.withdraw_time;
            end else begin
               rsp_word_in.status = wrct_pkg::STATUS_FULL;
            end
         end
         default: begin
            if (accept) begin
               req_in     = req_word;
               rd_addr_in = '0;
               hit_in     = 1'b0;
               free_in    = 1'b0;
               removed_in = '0;
            end
         end
      endcase

      // check the slot read in the previous cycle
      if (chk_vld_ff) begin
         if (req_ff.cmd == wrct_pkg::CMD_FLUSH) begin
            if (ram_rd_data.valid && peer_match) begin
               // drop the slot in place, behind the read pointer
               ram_wr_en         = 1'b1;
               ram_wr_addr       = chk_addr_ff;
               ram_wr_data.valid = 1'b0;
               if (removed_ff != wrct_pkg::REMOVED_MAX) begin
                  removed_in = removed_ff + wrct_pkg::REMOVED_BITS'(1);
               end
            end
         end else if (ram_rd_data.valid) begin
            if (!hit_ff && peer_match && key_match) begin
               hit_in       = 1'b1;
               hit_addr_in  = chk_addr_ff;
               hit_count_in = ram_rd_data.count;
            end
         end else if (!free_ff) begin
            free_in      = 1'b1;
            free_addr_in = chk_addr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wrct_pkg::ST_CLEAR;
         rd_addr_ff   <= '0;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_addr_ff   <= rd_addr_in;
         chk_vld_ff   <= chk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      chk_addr_ff  <= chk_addr_in;
      hit_ff       <= hit_in;
      hit_addr_ff  <= hit_addr_in;
      hit_count_ff <= hit_count_in;
      free_ff      <= free_in;
      free_addr_ff <= free_addr_in;
      removed_ff   <= removed_in;
      rsp_word_ff  <= rsp_word_in;
   end

   assign busy       = (state_ff != wrct_pkg::ST_IDLE);
   assign rsp_strobe = rsp_valid_ff;
   assign rsp_word   = rsp_word_ff;

   // a response follows the commit cycle and never repeats
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == wrct_pkg::ST_COMMIT))
      else $error("response without commit");

   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response held longer than one cycle");

   assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("busy not raised after accept");

   // only a flush writes the table while it is being swept
   assert property (@(posedge clock) disable iff (reset)
      (ram_wr_en && state_ff == wrct_pkg::ST_SCAN) |-> (req_ff.cmd == wrct_pkg::CMD_FLUSH))
      else $error("record wrote the table during scan");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_word.status != wrct_pkg::STATUS_FLUSHED) |-> (rsp_word.removed == '0))
      else $error("record response reports removed slots");

endmodule

// ===== tb/sv/tb.sv =====
// self-checking testbench for withdrawn_route_count_table_core
// keeps a shadow copy of the slot table, predicts one response per request word
// depends on wrct_pkg and the core rtl
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_SLOTS    = 64;
   localparam int KEY_BITS       = 40;
   localparam int RANDOM_WORDS   = 1000;
   // no word taken and no response seen for this many cycles ends the run;
   // it must exceed a request, the longest pause and the clearing pass
   localparam int WATCHDOG_LIMIT = 5000;

   typedef logic [wrct_pkg::PREFIX_FIELD_BITS-1:0] prefix_type;
   typedef logic [wrct_pkg::COUNT_BITS-1:0]        count_type;

   localparam prefix_type KEY_MASK =
      (KEY_BITS >= wrct_pkg::PREFIX_FIELD_BITS) ? '1 :
      ((prefix_type'(1) << KEY_BITS) - prefix_type'(1));

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   wrct_pkg::req_word_type req_word;
   logic                   rsp_strobe;
   wrct_pkg::rsp_word_type rsp_word;

   withdrawn_route_count_table_core #(
      .TABLE_ENTRIES   (TABLE_SLOTS),
      .PREFIX_KEY_BITS (KEY_BITS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

   // shadow of the slot table as the core should hold it
   bit          tbl_valid  [TABLE_SLOTS];
   logic [31:0] tbl_peer   [TABLE_SLOTS];
   prefix_type  tbl_prefix [TABLE_SLOTS];
   count_type   tbl_count  [TABLE_SLOTS];
   logic [31:0] tbl_time   [TABLE_SLOTS];

   // responses predicted at acceptance, oldest first
   wrct_pkg::rsp_word_type pending_replies[$];
   int                     mismatch_count = 0;
   int                     idle_cycles    = 0;
   // cleared for whole stretches of back-to-back requests
   bit                     gaps_enabled   = 1'b1;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // count plus one, held at the top
   function automatic count_type saturating_bump(input count_type v);
      return (v == '1) ? v : v + count_type'(1);
   endfunction

   // apply one request word to the shadow table and return the response it earns
   function automatic wrct_pkg::rsp_word_type route_table_apply(
      input wrct_pkg::req_word_type w);
      wrct_pkg::rsp_word_type r;
      prefix_type             key;
      int                     hit;
      int                     free_slot;
      r         = '0;
      key       = w.prefix_key & KEY_MASK;
      hit       = -1;
      free_slot = -1;
      if (w.cmd == wrct_pkg::CMD_FLUSH) begin
         // every slot of the peer goes, the removed tally saturates
         for (int i = 0; i < TABLE_SLOTS; i++) begin
            if (tbl_valid[i] && tbl_peer[i] == w.peer_id) begin
               tbl_valid[i] = 1'b0;
               if (r.removed != wrct_pkg::REMOVED_MAX)
                  r.removed = r.removed + wrct_pkg::REMOVED_BITS'(1);
            end
         end
         r.status = wrct_pkg::STATUS_FLUSHED;
      end else begin
         // lowest matching valid slot wins, else lowest free slot
         for (int i = 0; i < TABLE_SLOTS; i++) begin
            if (tbl_valid[i]) begin
               if (hit < 0 && tbl_peer[i] == w.peer_id && tbl_prefix[i] == key)
                  hit = i;
            end else if (free_slot < 0) begin
               free_slot = i;
            end
         end
         if (hit >= 0) begin
            tbl_count[hit] = saturating_bump(tbl_count[hit]);
            tbl_time[hit]  = w.withdraw_time;
            r.entry_count  = tbl_count[hit];
            r.status       = wrct_pkg::STATUS_UPDATED;
         end else if (free_slot >= 0) begin
            tbl_valid[free_slot]  = 1'b1;
            tbl_peer[free_slot]   = w.peer_id;
            tbl_prefix[free_slot] = key;
            tbl_count[free_slot]  = saturating_bump(w.prior_count);
            tbl_time[free_slot]   = w.withdraw_time;
            r.entry_count         = tbl_count[free_slot];
            r.status              = wrct_pkg::STATUS_INSERTED;
         end else begin
            // table full: nothing changes, count stays zero
            r.status = wrct_pkg::STATUS_FULL;
         end
      end
      return r;
   endfunction

   function automatic wrct_pkg::req_word_type route_word(input logic cmd,
                                                         input logic [31:0] peer,
                                                         input prefix_type prefix,
                                                         input logic [31:0] stamp,
                                                         input count_type prior);
      wrct_pkg::req_word_type w;
      w.cmd           = cmd;
      w.peer_id       = peer;
      w.prefix_key    = prefix;
      w.withdraw_time = stamp;
      w.prior_count   = prior;
      return w;
   endfunction

   function automatic wrct_pkg::req_word_type random_word();
      return route_word(1'($urandom_range(0, 1)), $urandom,
                        prefix_type'({$urandom, $urandom}), $urandom, $urandom);
   endfunction

   // present one word and hold it until the core takes it; the prediction is
   // made at the edge of acceptance so table order matches the core
   task automatic send_word(input wrct_pkg::req_word_type w);
      req_word <= w;
      start    <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      pending_replies = {pending_replies, route_table_apply(w)};
   endtask

   // random hold-off after a word: mostly none or short, some landing near the
   // end of the sweep, a few long; junk rides the bus while start is low
   task automatic random_pause();
      int pick;
      int cycles;
      pick = $urandom_range(0, 99);
      if (!gaps_enabled || pick < 45)
         cycles = 0;
      else if (pick < 80)
         cycles = $urandom_range(1, 8);
      else if (pick < 95)
         cycles = $urandom_range(TABLE_SLOTS - 4, TABLE_SLOTS + 12);
      else
         cycles = $urandom_range(TABLE_SLOTS + 13, 4 * TABLE_SLOTS);
      if (cycles > 0) begin
         start    <= 1'b0;
         req_word <= random_word();
         repeat (cycles) @(posedge clock);
      end
   endtask

   // one word, then a random hold-off
   task automatic send_then_idle(input wrct_pkg::req_word_type w);
      send_word(w);
      random_pause();
   endtask

   // insert, hit and saturation at the extremes of peer, prefix and count
   task automatic test_record_paths();
      send_then_idle(route_word(wrct_pkg::CMD_RECORD, 32'h0, '0, 32'h0, 32'h0));
      send_then_idle(route_word(wrct_pkg::CMD_RECORD, 32'h0, '0, 32'hFFFF_FFFF,
                                32'h1234_5678));
      // insert with prior at the top stays at the top
      send_then_idle(route_word(wrct_pkg::CMD_RECORD, 32'hFFFF_FFFF, '1, 32'h8000_0000,
                                32'hFFFF_FFFF));
      send_then_idle(route_word(wrct_pkg::CMD_RECORD, 32'hFFFF_FFFF, '1, 32'h0000_0001,
                                32'h0));
      // one below the top reaches it on insert, then holds on hit
      send_then_idle(route_word(wrct_pkg::CMD_RECORD, 32'hFFFF_FFFF, '0, 32'h5555_5555,
                                32'hFFFF_FFFE));
      send_then_idle(route_word(wrct_pkg::CMD_RECORD, 32'hFFFF_FFFF, '0, 32'hAAAA_AAAA,
                                32'h7));
      // same peer other prefix, same prefix other peer
      send_then_idle(route_word(wrct_pkg::CMD_RECORD, 32'h0, '1, 32'h0, 32'h5));
      send_then_idle(route_word(wrct_pkg::CMD_RECORD, 32'h1, '0, 32'hFFFF_FFFF,
                                32'h8000_0000));
      send_then_idle(route_word(wrct_pkg::CMD_RECORD, 32'h0, '1, 32'h1, 32'hFFFF_FFFF));
   endtask

   // flush of an absent peer, of several slots, and reuse of the freed slots
   task automatic test_flush_paths();
      send_then_idle(route_word(wrct_pkg::CMD_FLUSH, 32'h1234_5678, '1, $urandom, $urandom));
      send_then_idle(route_word(wrct_pkg::CMD_FLUSH, 32'hFFFF_FFFF, '0, $urandom, $urandom));
      // lowest freed slot takes the next new key
      send_then_idle(route_word(wrct_pkg::CMD_RECORD, 32'hFFFF_FFFF, '1, 32'h0, 32'h0));
      send_then_idle(route_word(wrct_pkg::CMD_RECORD, 32'h2, 40'h55_5555_5555, 32'h3,
                                32'h2));
      send_then_idle(route_word(wrct_pkg::CMD_FLUSH, 32'h0, '1, 32'hFFFF_FFFF,
                                32'hFFFF_FFFF));
      send_then_idle(route_word(wrct_pkg::CMD_FLUSH, 32'h0, '0, 32'h0, 32'h0));
      send_then_idle(route_word(wrct_pkg::CMD_FLUSH, 32'hFFFF_FFFF, '0, $urandom, $urandom));
      send_then_idle(route_word(wrct_pkg::CMD_FLUSH, 32'h1, '0, $urandom, $urandom));
      send_then_idle(route_word(wrct_pkg::CMD_FLUSH, 32'h2, '0, $urandom, $urandom));
   endtask

   // fill every slot with one peer, then a miss drops, a hit still updates and
   // a flush of that peer removes the whole table
   task automatic test_table_full();
      logic [31:0] owner;
      prefix_type  base;
      owner = $urandom;
      base  = prefix_type'({$urandom, $urandom});
      for (int i = 0; i < TABLE_SLOTS; i++) begin
         send_word(route_word(wrct_pkg::CMD_RECORD, owner, base + prefix_type'(i), $urandom,
                              $urandom_range(0, 100)));
         random_pause();
      end
      send_word(route_word(wrct_pkg::CMD_RECORD, owner, base - prefix_type'(1), $urandom,
                           $urandom));
      send_word(route_word(wrct_pkg::CMD_RECORD, ~owner, base, $urandom, $urandom));
      send_word(route_word(wrct_pkg::CMD_RECORD, owner, base, $urandom, $urandom));
      send_word(route_word(wrct_pkg::CMD_FLUSH, ~owner, base, $urandom, $urandom));
      random_pause();
      send_word(route_word(wrct_pkg::CMD_FLUSH, owner, '0, $urandom, $urandom));
      random_pause();
   endtask

   // random traffic over a small pool of keys so hits, refills and flushes of
   // live peers are common; the rest is fully random keys and stray flushes
   task automatic test_random_traffic(input int count);
      logic [31:0] peer_pool   [4];
      prefix_type  prefix_pool [8];
      logic [31:0] peer;
      prefix_type  prefix;
      count_type   prior;
      int          roll;
      int          first;
      peer_pool[0] = 32'h0;
      peer_pool[1] = 32'hFFFF_FFFF;
      peer_pool[2] = $urandom;
      peer_pool[3] = $urandom;
      prefix_pool[0] = '0;
      prefix_pool[1] = '1;
      for (int i = 2; i < 8; i++)
         prefix_pool[i] = prefix_type'({$urandom, $urandom});
      for (int n = 0; n < count; n++) begin
         // switch idling on or off for stretches of 50 words
         if (n % 50 == 0)
            gaps_enabled = ($urandom_range(0, 9) >= 3);
         roll = $urandom_range(0, 99);
         if (roll < 10) begin
            roll = $urandom_range(0, 9);
            if (roll < 4) begin
               peer = peer_pool[$urandom_range(0, 3)];
            end else begin
               // mostly the peer of some live slot, so stray entries drain too; else random
               peer  = $urandom;
               first = $urandom_range(0, TABLE_SLOTS - 1);
               if (roll < 8) begin
                  for (int k = 0; k < TABLE_SLOTS; k++) begin
                     if (tbl_valid[(first + k) % TABLE_SLOTS]) begin
                        peer = tbl_peer[(first + k) % TABLE_SLOTS];
                        break;
                     end
                  end
               end
            end
            send_word(route_word(wrct_pkg::CMD_FLUSH, peer,
                                 prefix_type'({$urandom, $urandom}), $urandom, $urandom));
         end else begin
            peer   = ($urandom_range(0, 99) < 85) ? peer_pool[$urandom_range(0, 3)] : $urandom;
            prefix = ($urandom_range(0, 99) < 70) ? prefix_pool[$urandom_range(0, 7)] :
                     prefix_type'({$urandom, $urandom});
            roll = $urandom_range(0, 9);
            if (roll < 4)
               prior = $urandom_range(0, 1000);
            else if (roll < 9)
               prior = $urandom;
            else
               prior = 32'hFFFF_FFFF - $urandom_range(0, 3);
            send_word(route_word(wrct_pkg::CMD_RECORD, peer, prefix, $urandom, prior));
         end
         random_pause();
      end
   endtask

   // response checker: the core cannot be stalled, so every strobe is a word
   always @(posedge clock) begin : check_replies
      wrct_pkg::rsp_word_type want;
      if (reset === 1'b0 && rsp_strobe === 1'b1) begin
         if (pending_replies.size() == 0) begin
            $display("%0t: unexpected response status %0d count %0d removed %0d",
                     $time, rsp_word.status, rsp_word.entry_count, rsp_word.removed);
            mismatch_count++;
         end else begin
            want = pending_replies.pop_front();
            if (rsp_word.status !== want.status) begin
               $display("%0t: status expected %0d actual %0d",
                        $time, want.status, rsp_word.status);
               mismatch_count++;
            end
            if (rsp_word.entry_count !== want.entry_count) begin
               $display("%0t: entry_count expected %0d actual %0d",
                        $time, want.entry_count, rsp_word.entry_count);
               mismatch_count++;
            end
            if (rsp_word.removed !== want.removed) begin
               $display("%0t: removed expected %0d actual %0d",
                        $time, want.removed, rsp_word.removed);
               mismatch_count++;
            end
         end
      end
   end

   // watchdog: any taken word or response counts as progress
   always @(posedge clock) begin
      if (reset === 1'b1 || (start === 1'b1 && busy === 1'b0) || rsp_strobe === 1'b1) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, idle_cycles);
         $display("Simulation FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      foreach (tbl_valid[i])
         tbl_valid[i] = 1'b0;
      start    <= 1'b0;
      req_word <= '0;
      reset    <= 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      // the core runs its clearing pass now; send_word just waits on busy

      test_record_paths();
      test_flush_paths();
      test_table_full();
      test_random_traffic(RANDOM_WORDS);

      start <= 1'b0;
      while (pending_replies.size() != 0)
         @(posedge clock);
      // room for a stray late response
      repeat (TABLE_SLOTS + 8) @(posedge clock);
      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/wrct_pkg.sv
hdl/wrct_ram.sv
hdl/withdrawn_route_count_table_core.sv
tb/sv/tb.sv
